// ===== rtl/core/c0eiu_pkg.sv =====
package c0eiu_pkg;

   localparam logic [2:0] OP_SET_IRQ  = 3'd0;
   localparam logic [2:0] OP_SET_HALT = 3'd1;
   localparam logic [2:0] OP_TAKE_EXC = 3'd2;
   localparam logic [2:0] OP_READ     = 3'd3;
   localparam logic [2:0] OP_WRITE    = 3'd4;

   localparam logic [2:0] SEL_SR     = 3'd0;
   localparam logic [2:0] SEL_CAUSE  = 3'd1;
   localparam logic [2:0] SEL_EPC    = 3'd2;
   localparam logic [2:0] SEL_TARGET = 3'd3;

   localparam logic [2:0]  IRQ_LINE_MAX  = 3'd5;
   localparam logic [4:0]  CAUSE_IP_LSB  = 5'd10;
   localparam int          SR_BEV_BIT    = 22;
   localparam logic [31:0] VEC_NORMAL    = 32'h8000_0080;
   localparam logic [31:0] VEC_BOOT      = 32'hBFC0_0180;
   localparam logic [31:0] SR_RESET      = 32'h0060_0000;
   localparam logic [31:0] IRQ_FIELD     = 32'h0000_FF00;
   localparam logic [31:0] EPC_WORD_MASK = 32'hFFFF_FFFC;
   localparam logic [31:0] PC_STEP       = 32'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  target_index;
      logic        level;
      logic [3:0]  exc_code;
      logic [31:0] pc;
      logic [31:0] next_pc;
      logic [31:0] next_pc_mask;
      logic [31:0] instr;
      logic [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic [31:0] handler;
      logic [31:0] read_data;
      logic        int_pending;
   } rsp_type;

endpackage

// ===== rtl/core/c0eiu_req_stage.sv =====
module c0eiu_req_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  c0eiu_pkg::req_type req_data,
   input  logic               advance,
   output logic               hold_valid,
   output c0eiu_pkg::req_type hold_data
);
   import c0eiu_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    load;

   assign req_ready  = !valid_ff || advance;
   assign load       = req_valid && req_ready;
   assign valid_in   = load || (valid_ff && !advance);
   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

endmodule

// ===== rtl/core/c0eiu_core.sv =====
module c0eiu_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  c0eiu_pkg::req_type req,
   output c0eiu_pkg::rsp_type rsp
);
   import c0eiu_pkg::*;

   logic [31:0] sr_ff, sr_in;
   logic [31:0] cause_ff, cause_in;
   logic [31:0] epc_ff, epc_in;
   logic [31:0] target_ff, target_in;
   logic        halted_ff, halted_in;
   logic        in_slot;
   logic        taken;
   logic [4:0]  ip_bit;

   assign in_slot = !req.next_pc_mask[0];
   assign taken   = req.next_pc_mask[1:0] == 2'b00;
   assign ip_bit  = CAUSE_IP_LSB + {2'b00, req.target_index};

   always_comb begin
      sr_in           = sr_ff;
      cause_in        = cause_ff;
      epc_in          = epc_ff;
      target_in       = target_ff;
      halted_in       = halted_ff;
      rsp.handler     = '0;
      rsp.read_data   = '0;
      case (req.op)
         OP_SET_IRQ: begin
            if (req.target_index <= IRQ_LINE_MAX) begin
               cause_in[ip_bit] = req.level;
            end
         end
         OP_SET_HALT: begin
            halted_in = req.level;
         end
         OP_TAKE_EXC: begin
            rsp.handler = sr_ff[SR_BEV_BIT] ? VEC_BOOT : VEC_NORMAL;
            epc_in      = in_slot ? (req.pc - PC_STEP) : req.pc;
            if (in_slot) begin
               target_in = (req.pc & (req.next_pc_mask | 32'd3)) + req.next_pc;
            end
            // push the ie/ku stack
            sr_in    = {sr_ff[31:6], sr_ff[3:0], 2'b00};
            cause_in = (cause_ff & IRQ_FIELD)
                     | {in_slot, taken, req.instr[27:26], 22'd0, req.exc_code, 2'b00};
         end
         OP_READ: begin
            case (req.target_index)
               SEL_SR:     rsp.read_data = sr_ff;
               SEL_CAUSE:  rsp.read_data = cause_ff;
               SEL_EPC:    rsp.read_data = epc_ff;
               SEL_TARGET: rsp.read_data = target_ff;
               default:    rsp.read_data = '0;
            endcase
         end
         OP_WRITE: begin
            case (req.target_index)
               SEL_SR:    sr_in    = req.write_value;
               SEL_CAUSE: cause_in = req.write_value;
               SEL_EPC:   epc_in   = req.write_value & EPC_WORD_MASK;
               default:   ;
            endcase
         end
         default: ;
      endcase
      rsp.int_pending = halted_in
                      || (((sr_in & cause_in & IRQ_FIELD) != '0) && sr_in[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_ff     <= SR_RESET;
         cause_ff  <= '0;
         epc_ff    <= '0;
         target_ff <= '0;
         halted_ff <= 1'b0;
      end else if (advance) begin
         sr_ff     <= sr_in;
         cause_ff  <= cause_in;
         epc_ff    <= epc_in;
         target_ff <= target_in;
         halted_ff <= halted_in;
      end
   end

`ifndef SYNTHESIS
   a_exc_clears_ie: assert property (@(posedge clock) disable iff (reset)
      advance && req.op == OP_TAKE_EXC |=> sr_ff[1:0] == 2'b00)
      else $error("exception left current ie/ku set");
   a_exc_cause_gaps: assert property (@(posedge clock) disable iff (reset)
      advance && req.op == OP_TAKE_EXC |=> cause_ff[1:0] == 2'b00
         && cause_ff[7:6] == 2'b00 && cause_ff[27:16] == '0)
      else $error("exception cause has stray bits");
   a_epc_aligned: assert property (@(posedge clock) disable iff (reset)
      advance && req.op == OP_WRITE && req.target_index == SEL_EPC
      |=> epc_ff[1:0] == 2'b00)
      else $error("epc write kept low bits");
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(sr_ff) && $stable(cause_ff) && $stable(epc_ff)
         && $stable(target_ff) && $stable(halted_ff))
      else $error("state changed without a request");
`endif

endmodule

// ===== rtl/core/cop0_exception_interrupt_unit.sv =====
// Coprocessor-0 exception and interrupt unit (SR, cause, EPC, branch target,
// halt). Each request is held in an input register, processed by one level of
// combinational update logic and lands in a result register, so one request is
// taken per cycle while the response side is ready; its response becomes valid
// once it reaches the result register. int_pending reflects the state after the request.
module cop0_exception_interrupt_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [2:0]  req_target_index,
   input  logic        req_level,
   input  logic [3:0]  req_exc_code,
   input  logic [31:0] req_pc,
   input  logic [31:0] req_next_pc,
   input  logic [31:0] req_next_pc_mask,
   input  logic [31:0] req_instr,
   input  logic [31:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_handler,
   output logic [31:0] rsp_read_data,
   output logic        rsp_int_pending
);
   import c0eiu_pkg::*;

   req_type req_data;
   req_type hold_data;
   rsp_type core_rsp;
   logic    hold_valid;
   logic    advance;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   assign req_data = '{op: req_op, target_index: req_target_index, level: req_level,
                       exc_code: req_exc_code, pc: req_pc, next_pc: req_next_pc,
                       next_pc_mask: req_next_pc_mask, instr: req_instr,
                       write_value: req_write_value};

   assign advance      = hold_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   c0eiu_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_data  (hold_data)
   );

   c0eiu_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (hold_data),
      .rsp     (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_handler     = rsp_data_ff.handler;
   assign rsp_read_data   = rsp_data_ff.read_data;
   assign rsp_int_pending = rsp_data_ff.int_pending;

`ifndef SYNTHESIS
   a_handler_or_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_handler != '0 |-> rsp_read_data == '0)
      else $error("response carries both a vector and read data");
   a_no_load_when_full: assert property (@(posedge clock) disable iff (reset)
      hold_valid && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline is blocked");
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed request produced no response");
`endif

endmodule

// ===== tb/cop0_exception_interrupt_unit_test.sv =====
`timescale 1ns / 1ps

import c0eiu_pkg::*;

class cop0_shadow;
   logic [31:0] status_r;
   logic [31:0] cause_r;
   logic [31:0] epc_r;
   logic [31:0] target_r;
   logic        halted_r;
   rsp_type     awaited[$];
   int          error_count;

   function new();
      status_r    = SR_RESET;
      cause_r     = '0;
      epc_r       = '0;
      target_r    = '0;
      halted_r    = 1'b0;
      error_count = 0;
   endfunction

   function void note_request(req_type r);
      rsp_type expected;
      logic    in_slot;
      logic    taken;
      expected = '0;
      in_slot  = ~r.next_pc_mask[0];
      taken    = (r.next_pc_mask[1:0] == 2'b00);
      case (r.op)
         OP_SET_IRQ: begin
            if (r.target_index <= IRQ_LINE_MAX) begin
               cause_r[CAUSE_IP_LSB + r.target_index] = r.level;
            end
         end
         OP_SET_HALT: begin
            halted_r = r.level;
         end
         OP_TAKE_EXC: begin
            expected.handler = status_r[SR_BEV_BIT] ? VEC_BOOT : VEC_NORMAL;
            epc_r = r.pc;
            if (in_slot) begin
               epc_r    = r.pc - PC_STEP;
               target_r = (r.pc & (r.next_pc_mask | 32'h3)) + r.next_pc;
            end
            // push the kernel/user and interrupt-enable stack
            status_r[5:0]  = {status_r[3:0], 2'b00};
            cause_r        = (cause_r & IRQ_FIELD) | ({28'd0, r.exc_code} << 2);
            cause_r[31]    = in_slot;
            cause_r[30]    = taken;
            cause_r[29:28] = r.instr[27:26];
         end
         OP_READ: begin
            case (r.target_index)
               SEL_SR:     expected.read_data = status_r;
               SEL_CAUSE:  expected.read_data = cause_r;
               SEL_EPC:    expected.read_data = epc_r;
               SEL_TARGET: expected.read_data = target_r;
               default:    expected.read_data = '0;
            endcase
         end
         OP_WRITE: begin
            case (r.target_index)
               SEL_SR:    status_r = r.write_value;
               SEL_CAUSE: cause_r  = r.write_value;
               SEL_EPC:   epc_r    = r.write_value & EPC_WORD_MASK;
               default:   ;
            endcase
         end
         default: ;
      endcase
      expected.int_pending = halted_r ||
                             (((status_r & cause_r & IRQ_FIELD) != '0) && status_r[0]);
      awaited.push_back(expected);
   endfunction

   task report_error(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task check_response(rsp_type got);
      rsp_type want;
      if (awaited.size() == 0) begin
         report_error($sformatf("response with nothing awaited (handler %h data %h)",
                                got.handler, got.read_data));
      end else begin
         want = awaited.pop_front();
         if (got.handler !== want.handler)
            report_error($sformatf("handler %h, expected %h", got.handler, want.handler));
         if (got.read_data !== want.read_data)
            report_error($sformatf("read_data %h, expected %h",
                                   got.read_data, want.read_data));
         if (got.int_pending !== want.int_pending)
            report_error($sformatf("int_pending %b, expected %b",
                                   got.int_pending, want.int_pending));
      end
   endtask
endclass

module cop0_exception_interrupt_unit_test;

   localparam int         CYCLE_LIMIT     = 200000;
   localparam int         ITEMS_PER_PHASE = 300;
   localparam int         DRAIN_CYCLES    = 12;
   localparam logic [2:0] OP_SPARE_FIRST  = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST   = 3'd7;
   localparam logic [2:0] SEL_LAST        = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_op;
   logic [2:0]  req_target_index;
   logic        req_level;
   logic [3:0]  req_exc_code;
   logic [31:0] req_pc;
   logic [31:0] req_next_pc;
   logic [31:0] req_next_pc_mask;
   logic [31:0] req_instr;
   logic [31:0] req_write_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_handler;
   logic [31:0] rsp_read_data;
   logic        rsp_int_pending;

   int          send_idle_pct;
   int          stall_pct;
   int          cycle_count;
   cop0_shadow  shadow;
   rsp_type     seen;

   cop0_exception_interrupt_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_target_index (req_target_index),
      .req_level        (req_level),
      .req_exc_code     (req_exc_code),
      .req_pc           (req_pc),
      .req_next_pc      (req_next_pc),
      .req_next_pc_mask (req_next_pc_mask),
      .req_instr        (req_instr),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_handler      (rsp_handler),
      .rsp_read_data    (rsp_read_data),
      .rsp_int_pending  (rsp_int_pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.handler     = rsp_handler;
         seen.read_data   = rsp_read_data;
         seen.int_pending = rsp_int_pending;
         shadow.check_response(seen);
      end
      rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   function automatic req_type make_request(logic [2:0] op, logic [2:0] sel, logic lvl,
                                            logic [3:0] code, logic [31:0] pc,
                                            logic [31:0] np, logic [31:0] npm,
                                            logic [31:0] iw, logic [31:0] wv);
      req_type r;
      r.op           = op;
      r.target_index = sel;
      r.level        = lvl;
      r.exc_code     = code;
      r.pc           = pc;
      r.next_pc      = np;
      r.next_pc_mask = npm;
      r.instr        = iw;
      r.write_value  = wv;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick           = $urandom_range(99);
      r.target_index = 3'($urandom_range(SEL_LAST));
      r.level        = 1'($urandom_range(1));
      r.exc_code     = 4'($urandom_range(15));
      r.pc           = $urandom;
      r.next_pc      = $urandom;
      r.next_pc_mask = $urandom;
      r.instr        = $urandom;
      r.write_value  = $urandom;
      if (pick < 22) begin
         r.op = OP_SET_IRQ;
      end else if (pick < 30) begin
         r.op    = OP_SET_HALT;
         // keep halt mostly clear so the interrupt mask stays visible
         r.level = ($urandom_range(99) < 30);
      end else if (pick < 48) begin
         r.op = OP_TAKE_EXC;
      end else if (pick < 70) begin
         r.op = OP_READ;
      end else if (pick < 95) begin
         r.op = OP_WRITE;
      end else begin
         r.op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      end
      return r;
   endfunction

   task automatic send_request(input req_type r);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_op           <= r.op;
      req_target_index <= r.target_index;
      req_level        <= r.level;
      req_exc_code     <= r.exc_code;
      req_pc           <= r.pc;
      req_next_pc      <= r.next_pc;
      req_next_pc_mask <= r.next_pc_mask;
      req_instr        <= r.instr;
      req_write_value  <= r.write_value;
      do @(posedge clock); while (!req_ready);
      shadow.note_request(r);
   endtask

   task automatic run_directed();
      send_request(make_request(OP_READ, SEL_SR, 1'b0, 4'h0, '0, '0, '0, '0, '0));
      // delay slot, not taken, pc wraps below zero, boot vector
      send_request(make_request(OP_TAKE_EXC, SEL_SR, 1'b0, 4'hF, 32'h0000_0000,
                                32'h0000_0010, 32'hFFFF_FFFE, 32'hFFFF_FFFF, '0));
      send_request(make_request(OP_READ, SEL_EPC, 1'b0, 4'h0, '0, '0, '0, '0, '0));
      // branch taken, target wraps
      send_request(make_request(OP_TAKE_EXC, SEL_SR, 1'b1, 4'h0, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF));
      send_request(make_request(OP_READ, SEL_TARGET, 1'b0, 4'h0, '0, '0, '0, '0, '0));
      send_request(make_request(OP_READ, SEL_CAUSE, 1'b0, 4'h0, '0, '0, '0, '0, '0));
      send_request(make_request(OP_WRITE, SEL_SR, 1'b0, 4'h0, '0, '0, '0, '0, 32'h0000_FF01));
      send_request(make_request(OP_SET_IRQ, 3'd0, 1'b1, 4'h0, '0, '0, '0, '0, '0));
      send_request(make_request(OP_SET_IRQ, IRQ_LINE_MAX, 1'b1, 4'h0, '0, '0, '0, '0, '0));
      send_request(make_request(OP_SET_IRQ, IRQ_LINE_MAX + 3'd1, 1'b1, 4'h0,
                                '0, '0, '0, '0, '0));
      send_request(make_request(OP_SET_IRQ, SEL_LAST, 1'b1, 4'h0, '0, '0, '0, '0, '0));
      send_request(make_request(OP_READ, SEL_CAUSE, 1'b0, 4'h0, '0, '0, '0, '0, '0));
      send_request(make_request(OP_SET_IRQ, 3'd0, 1'b0, 4'h0, '0, '0, '0, '0, '0));
      // normal vector, no delay slot
      send_request(make_request(OP_TAKE_EXC, SEL_SR, 1'b0, 4'h8, 32'h1234_5678,
                                32'hFFFF_FFFF, 32'h0000_0001, 32'h0800_0000, '0));
      send_request(make_request(OP_SET_HALT, SEL_SR, 1'b1, 4'h0, '0, '0, '0, '0, '0));
      send_request(make_request(OP_SET_HALT, SEL_SR, 1'b0, 4'h0, '0, '0, '0, '0, '0));
      send_request(make_request(OP_WRITE, SEL_SR, 1'b0, 4'h0, '0, '0, '0, '0, 32'hFFFF_FFFF));
      send_request(make_request(OP_WRITE, SEL_CAUSE, 1'b0, 4'h0, '0, '0, '0, '0,
                                32'hFFFF_FFFF));
      send_request(make_request(OP_WRITE, SEL_EPC, 1'b0, 4'h0, '0, '0, '0, '0, 32'hFFFF_FFFF));
      send_request(make_request(OP_WRITE, SEL_TARGET, 1'b0, 4'h0, '0, '0, '0, '0,
                                32'h5555_5555));
      send_request(make_request(OP_WRITE, SEL_LAST, 1'b0, 4'h0, '0, '0, '0, '0, 32'hAAAA_AAAA));
      send_request(make_request(OP_READ, SEL_EPC, 1'b0, 4'h0, '0, '0, '0, '0, '0));
      send_request(make_request(OP_READ, SEL_TARGET + 3'd1, 1'b0, 4'h0, '0, '0, '0, '0, '0));
      send_request(make_request(OP_READ, SEL_LAST, 1'b0, 4'h0, '0, '0, '0, '0, '0));
      send_request(make_request(OP_SPARE_FIRST, SEL_SR, 1'b1, 4'hF, '1, '1, '1, '1, '1));
      send_request(make_request(OP_SPARE_LAST, SEL_CAUSE, 1'b1, 4'hF, '1, '1, '1, '1, '1));
   endtask

   initial begin
      shadow           = new();
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = OP_SET_IRQ;
      req_target_index = SEL_SR;
      req_level        = 1'b0;
      req_exc_code     = '0;
      req_pc           = '0;
      req_next_pc      = '0;
      req_next_pc_mask = '0;
      req_instr        = '0;
      req_write_value  = '0;
      rsp_ready        = 1'b0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      cycle_count      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         repeat (ITEMS_PER_PHASE) send_request(random_request());
      end
      req_valid <= 1'b0;
      while (shadow.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/c0eiu_pkg.sv
rtl/core/c0eiu_req_stage.sv
rtl/core/c0eiu_core.sv
rtl/core/cop0_exception_interrupt_unit.sv
tb/cop0_exception_interrupt_unit_test.sv
